// ===== rtl/pse_pkg.sv =====
`timescale 1ns / 1ps

package pse_pkg;

  // Token kinds carried on the input tuser field.
  localparam logic [2:0] FUNC_PUSH = 3'd0;
  localparam logic [2:0] FUNC_ADD  = 3'd1;
  localparam logic [2:0] FUNC_SUB  = 3'd2;
  localparam logic [2:0] FUNC_MUL  = 3'd3;
  localparam logic [2:0] FUNC_DIV  = 3'd4;
  localparam logic [2:0] FUNC_MOD  = 3'd5;
  localparam logic [2:0] FUNC_POW  = 3'd6;

  // Status codes returned with each result.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
  localparam logic [2:0] STAT_DIV_ZERO  = 3'd3;
  localparam logic [2:0] STAT_LEFTOVER  = 3'd4;

  // Source of the value written back to the top of stack.
  localparam logic [2:0] WB_ALU  = 3'd0;
  localparam logic [2:0] WB_DIV  = 3'd1;
  localparam logic [2:0] WB_MOD  = 3'd2;
  localparam logic [2:0] WB_POW  = 3'd3;
  localparam logic [2:0] WB_ZERO = 3'd4;

  // Divider sequencing.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DCNT_W    = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_tok;
    logic       push;
    logic       set_err;
    logic [2:0] err_code;
    logic       ld_ops;
    logic       div_init;
    logic       div_step;
    logic       pow_init;
    logic       pow_step;
    logic       wb;
    logic [2:0] wb_sel;
    logic       emit;
    logic       clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] func;
    logic       last;
    logic       err_nz;
    logic       full;
    logic       lt2;
    logic       b_zero;
    logic       b_neg;
    logic       div_done;
    logic       pow_done;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/pse_ctrl.sv =====
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  pse_pkg::sts_t  sts,
  output pse_pkg::cmd_t  cmd
);
  import pse_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_OPS    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_POW    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing of one token and the commands for each step.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_tok = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        if (!sts.err_nz) begin
          if (sts.func == FUNC_PUSH) begin
            if (sts.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = STAT_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (sts.func <= FUNC_POW) begin
            if (sts.lt2) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = STAT_UNDERFLOW;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd.ld_ops = 1'b1;
        state_nxt  = S_OPS;
      end
      S_OPS: begin
        state_nxt = S_FINISH;
        unique case (sts.func) inside
          FUNC_DIV, FUNC_MOD: begin
            if (sts.b_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = STAT_DIV_ZERO;
              cmd.wb       = 1'b1;
              cmd.wb_sel   = WB_ZERO;
            end else begin
              cmd.div_init = 1'b1;
              state_nxt    = S_DIV;
            end
          end
          FUNC_POW: begin
            if (sts.b_neg) begin
              cmd.wb     = 1'b1;
              cmd.wb_sel = WB_ZERO;
            end else begin
              cmd.pow_init = 1'b1;
              state_nxt    = S_POW;
            end
          end
          default: begin
            cmd.wb     = 1'b1;
            cmd.wb_sel = WB_ALU;
          end
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.wb     = 1'b1;
          cmd.wb_sel = (sts.func == FUNC_DIV) ? WB_DIV : WB_MOD;
          state_nxt  = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_POW: begin
        if (sts.pow_done) begin
          cmd.wb     = 1'b1;
          cmd.wb_sel = WB_POW;
          state_nxt  = S_FINISH;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pse_datapath.sv =====
`timescale 1ns / 1ps

module pse_datapath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pse_pkg::cmd_t  cmd,
  output pse_pkg::sts_t  sts,
  input  logic [2:0]     in_func,
  input  logic [31:0]    in_value,
  input  logic           in_last,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_value,
  output logic [2:0]     out_status
);
  import pse_pkg::*;

  localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

  // Stack below the top entry; the top entry lives in tos_r.
  logic [31:0]       stack_mem [STACK_DEPTH];
  logic [31:0]       rd_data_r;
  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  lvl_m1;
  logic [LVL_W-1:0]  lvl_m2;
  logic [31:0]       tos_r;
  logic [2:0]        err_r;

  // Current token.
  logic [2:0]        func_r;
  logic [31:0]       val_r;
  logic              last_r;

  // Operands and arithmetic units.
  logic [31:0]       a_r;
  logic [31:0]       b_r;
  logic [31:0]       dvs_r;
  logic [31:0]       rem_r;
  logic [31:0]       quo_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [32:0]       div_sh;
  logic [32:0]       div_diff;
  logic [31:0]       acc_r;
  logic [31:0]       base_r;
  logic [30:0]       exp_r;
  logic [31:0]       alu_res;
  logic [31:0]       wb_val;

  // Output register.
  logic              out_valid_r;
  logic [31:0]       out_value_r;
  logic [2:0]        out_status_r;
  logic [2:0]        fin_status;

  assign lvl_m1 = level_r - LVL_W'(1);
  assign lvl_m2 = level_r - LVL_W'(2);

  // Token capture.
  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      func_r <= in_func;
      val_r  <= in_value;
      last_r <= in_last;
    end
  end

  // Stack memory: one write port for spills, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push && (level_r != '0)) begin
      stack_mem[lvl_m1[ADDR_W-1:0]] <= tos_r;
    end
    rd_data_r <= stack_mem[lvl_m2[ADDR_W-1:0]];
  end

  // Result selection for the write-back to the top of stack.
  always_comb begin
    case (func_r)
      FUNC_ADD: alu_res = a_r + b_r;
      FUNC_SUB: alu_res = a_r - b_r;
      default:  alu_res = a_r * b_r;
    endcase
    case (cmd.wb_sel)
      WB_ALU:  wb_val = alu_res;
      WB_DIV:  wb_val = (a_r[31] ^ b_r[31]) ? (32'd0 - quo_r) : quo_r;
      WB_MOD:  wb_val = a_r[31] ? (32'd0 - rem_r) : rem_r;
      WB_POW:  wb_val = acc_r;
      default: wb_val = 32'd0;
    endcase
  end

  // Top of stack, level and sticky error.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      err_r   <= STAT_OK;
    end else begin
      if (cmd.push) begin
        tos_r   <= val_r;
        level_r <= level_r + LVL_W'(1);
      end
      if (cmd.wb) begin
        tos_r   <= wb_val;
        level_r <= lvl_m1;
      end
      if (cmd.set_err) begin
        err_r <= cmd.err_code;
      end
      if (cmd.clear) begin
        level_r <= '0;
        err_r   <= STAT_OK;
      end
    end
  end

  // Operand latch: a from the stack memory, b from the top register.
  always_ff @(posedge clk) begin
    if (cmd.ld_ops) begin
      a_r <= rd_data_r;
      b_r <= tos_r;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign div_sh   = {rem_r, quo_r[31]};
  assign div_diff = div_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= 32'd0;
      quo_r  <= a_r[31] ? (32'd0 - a_r) : a_r;
      dvs_r  <= b_r[31] ? (32'd0 - b_r) : b_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_diff[32] ? div_sh[31:0] : div_diff[31:0];
      quo_r  <= {quo_r[30:0], ~div_diff[32]};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // Square-and-multiply, one exponent bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.pow_init) begin
      acc_r  <= 32'd1;
      base_r <= a_r;
      exp_r  <= b_r[30:0];
    end else if (cmd.pow_step) begin
      if (exp_r[0]) begin
        acc_r <= acc_r * base_r;
      end
      base_r <= base_r * base_r;
      exp_r  <= exp_r >> 1;
    end
  end

  // Final status of the expression.
  always_comb begin
    if (err_r != STAT_OK) begin
      fin_status = err_r;
    end else if (level_r == '0) begin
      fin_status = STAT_UNDERFLOW;
    end else if (level_r != LVL_W'(1)) begin
      fin_status = STAT_LEFTOVER;
    end else begin
      fin_status = STAT_OK;
    end
  end

  // Output register; holds the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= fin_status;
      out_value_r  <= (fin_status == STAT_OK) ? tos_r : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Status to the controller.
  always_comb begin
    sts          = '0;
    sts.func     = func_r;
    sts.last     = last_r;
    sts.err_nz   = (err_r != STAT_OK);
    sts.full     = (level_r >= LVL_W'(STACK_DEPTH));
    sts.lt2      = (level_r < LVL_W'(2));
    sts.b_zero   = (b_r == 32'd0);
    sts.b_neg    = b_r[31];
    sts.div_done = (dcnt_r == DCNT_W'(DIV_STEPS));
    sts.pow_done = (exp_r == '0);
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Takes one token per transaction and accepts the next token only once the current one's
// work is done. Pow steps once per significant exponent bit, and div and mod run the
// 32-step divider; a negative exponent or a zero divisor skips the iteration. After the
// last token's work, the finish step loads the result into an output register, which holds
// it until taken; a result still waiting there stalls the next final token.
// Synchronous active-low reset empties the stack, clears the error and the output.
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_value
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [2:0]  out_tuser   // [2:0] status
);
  import pse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stack, arithmetic units and output register.
  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_tuser),
    .in_value   (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule
